[hdl/assert_macros.svh]
// Assertion helper macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, disabled in reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Clocked next-cycle implication check, disabled in reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/imh_pkg.sv]
// ----------------------------------------------------------------------------
// imh_pkg
// Types and constants shared by the indexed min-heap modules.
// ----------------------------------------------------------------------------
`default_nettype none
package imh_pkg;
  localparam int unsigned HeapDepth = 1024;
  localparam int unsigned KeyCount  = 65536;
  localparam int unsigned SlotW     = $clog2(HeapDepth);
  localparam int unsigned CountW    = SlotW + 1;
  localparam int unsigned KeyW      = $clog2(KeyCount);
  localparam int unsigned MapW      = SlotW + 2;
  localparam logic [31:0] StopReset = 32'd7679744;

  // position map encoding: {tag, slot}
  typedef enum logic [1:0] {
    MAP_ABSENT = 2'd0,
    MAP_IN     = 2'd1,
    MAP_DONE   = 2'd2
  } map_tag_e;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_UPDATE  = 2'd1,
    CMD_EXTRACT = 2'd2,
    CMD_LOOKUP  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOKEY    = 3'd3,
    ST_SENTINEL = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] seed;
    logic [31:0] pri;
  } entry_t;

  // map memory request
  typedef struct packed {
    logic            we;
    logic [KeyW-1:0] addr;
    logic [MapW-1:0] wdata;
  } map_req_t;
endpackage
`default_nettype wire

[hdl/imh_map_ram.sv]
// ----------------------------------------------------------------------------
// imh_map_ram
// Position map memory, one port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module imh_map_ram import imh_pkg::*; (
  input  wire logic            clk_i,
  input  wire map_req_t        req_i,
  output logic     [MapW-1:0]  rdata_o
);
  logic [MapW-1:0] mem [KeyCount];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr];
  end
endmodule
`default_nettype wire

[hdl/imh_heap_ram.sv]
// ----------------------------------------------------------------------------
// imh_heap_ram
// Heap slot memory (key, seed, priority), one port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module imh_heap_ram import imh_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [SlotW-1:0] addr_i,
  input  wire entry_t           wdata_i,
  output entry_t                rdata_o
);
  entry_t mem [HeapDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

[hdl/indexed_min_heap.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap with position map and decrease/increase key.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_ready | command, voxel_key, seed_tag, priority_req
// out     | output    | out_valid/out_ready | status, out_key, out_seed, out_priority,
//         |           |                     | key_state, entry_count
// cfg     | input     | cfg_we (no wait)    | cfg_wdata (stop_priority)
//
// After reset a clearing pass writes every position map entry to absent, with
// in_ready low meanwhile.
// Lookups and error cases finish without moving any entry; an insert or update
// moves its entry up or down level by level, an extract moves the last entry
// down from the root level by level. One sequencer drives a single port of each
// memory and a shared priority comparator (the sift-down step adds one compare
// against the entry being placed), so the memory ports set the pace.
// Results wait in an output register; the block takes no item until it is
// taken, and accepts the next item in the cycle after that.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_min_heap import imh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] voxel_key_i,
  input  wire logic [15:0] seed_tag_i,
  input  wire logic [31:0] priority_req_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status_o,
  output logic [15:0]      out_key_o,
  output logic [15:0]      out_seed_o,
  output logic [31:0]      out_priority_o,
  output logic [1:0]       key_state_o,
  output logic [10:0]      entry_count_o,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  typedef enum logic [16:0] {
    S_CLEAR  = 17'h00001,
    S_IDLE   = 17'h00002,
    S_MAPRD  = 17'h00004, // map read issued
    S_DECIDE = 17'h00008,
    S_UPRD   = 17'h00010, // parent read issued
    S_UPCMP  = 17'h00020,
    S_UPMAP  = 17'h00040, // update map of moved parent
    S_DNRDL  = 17'h00080, // left child read issued
    S_DNRDR  = 17'h00100, // right child read issued
    S_DNCMP  = 17'h00200,
    S_DNMAP  = 17'h00400,
    S_PLACE  = 17'h00800, // write final entry
    S_TOPRD  = 17'h01000,
    S_TOPCHK = 17'h02000,
    S_LASTRD = 17'h04000,
    S_LKRD   = 17'h08000,
    S_OUT    = 17'h10000
  } state_e;

  state_e               state_q, state_d;
  logic [KeyW-1:0]      clr_q, clr_d;
  logic [31:0]          stop_q;
  logic [1:0]           cmd_q, cmd_d;
  entry_t               cur_q, cur_d;     // entry being placed
  logic [SlotW-1:0]     slot_q, slot_d;   // hole position
  logic [SlotW-1:0]     start_q, start_d;
  logic [CountW-1:0]    size_q, size_d;
  logic                 moved_q, moved_d;
  entry_t               left_q, left_d;   // left child held for compare
  entry_t               pick_q, pick_d;   // entry moved into hole
  logic [SlotW-1:0]     pslot_q, pslot_d;
  logic [MapW-1:0]      where_q, where_d;
  logic                 ov_q, ov_d;
  logic [2:0]           st_q, st_d;
  entry_t               oent_q, oent_d;
  logic [1:0]           ks_q, ks_d;

  map_req_t             mreq;
  logic [MapW-1:0]      mrd;
  logic                 hwe;
  logic [SlotW-1:0]     haddr;
  entry_t               hwd, hrd;

  imh_map_ram u_map (.clk_i(clk_i), .req_i(mreq), .rdata_o(mrd));
  imh_heap_ram u_heap (.clk_i(clk_i), .we_i(hwe), .addr_i(haddr), .wdata_i(hwd),
                       .rdata_o(hrd));

  // shared compare unit: right vs left child in the sift-down pick,
  // entry vs parent otherwise
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    if (state_q == S_DNCMP) begin
      cmp_a = hrd.pri; cmp_b = left_q.pri;
    end else begin
      cmp_a = cur_q.pri; cmp_b = hrd.pri;
    end
  end

  logic [CountW-1:0] lchild, rchild;
  assign lchild = {slot_q, 1'b1};
  assign rchild = lchild + CountW'(1);
  logic [SlotW-1:0] parent;
  assign parent = SlotW'((slot_q - SlotW'(1)) >> 1);

  logic present;
  assign present = (where_q[MapW-1 -: 2] == MAP_IN) &&
                   ({1'b0, where_q[SlotW-1:0]} < size_q);

  always_comb begin
    state_d = state_q; clr_d = clr_q; cmd_d = cmd_q; cur_d = cur_q;
    slot_d = slot_q; start_d = start_q; size_d = size_q; moved_d = moved_q;
    left_d = left_q; pick_d = pick_q; pslot_d = pslot_q; where_d = where_q;
    ov_d = ov_q; st_d = st_q; oent_d = oent_q; ks_d = ks_q;
    mreq = '{we: 1'b0, addr: cur_q.key, wdata: '0};
    hwe = 1'b0; haddr = slot_q; hwd = cur_q;
    in_ready = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mreq = '{we: 1'b1, addr: clr_q, wdata: {MAP_ABSENT, SlotW'(0)}};
        clr_d = clr_q + KeyW'(1);
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !ov_q;
        if (in_valid && !ov_q) begin
          cmd_d = command_i;
          cur_d = '{key: voxel_key_i, seed: seed_tag_i, pri: priority_req_i};
          st_d = ST_OK; oent_d = '0; ks_d = MAP_ABSENT;
          mreq.addr = voxel_key_i;
          haddr = '0;
          state_d = (command_i == CMD_EXTRACT) ? S_TOPRD : S_MAPRD;
        end
      end
      S_MAPRD: begin
        where_d = mrd;
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        haddr = where_q[SlotW-1:0];
        moved_d = 1'b0;
        if (cmd_q == CMD_LOOKUP) begin
          oent_d.key = cur_q.key;
          if (present) begin
            ks_d = MAP_IN; state_d = S_LKRD;
          end else begin
            ks_d = (where_q[MapW-1 -: 2] == MAP_DONE) ? MAP_DONE : MAP_ABSENT;
            state_d = S_OUT;
          end
        end else if (present) begin
          start_d = where_q[SlotW-1:0]; slot_d = where_q[SlotW-1:0];
          state_d = S_UPRD;
        end else if (cmd_q == CMD_UPDATE) begin
          st_d = ST_NOKEY; state_d = S_OUT;
        end else if (size_q >= CountW'(HeapDepth)) begin
          st_d = ST_FULL; state_d = S_OUT;
        end else begin
          slot_d = SlotW'(size_q); start_d = SlotW'(size_q);
          size_d = size_q + CountW'(1);
          state_d = S_UPRD;
        end
      end
      S_LKRD: begin
        oent_d.seed = hrd.seed; oent_d.pri = hrd.pri;
        state_d = S_OUT;
      end
      S_UPRD: begin
        haddr = parent;
        if (slot_q == '0) state_d = moved_q ? S_PLACE : S_DNRDL;
        else state_d = S_UPCMP;
      end
      S_UPCMP: begin
        if (cmp_lt) begin
          hwe = 1'b1; haddr = slot_q; hwd = hrd;
          pick_d = hrd; pslot_d = slot_q;
          slot_d = parent; moved_d = 1'b1;
          state_d = S_UPMAP;
        end else begin
          state_d = moved_q ? S_PLACE : S_DNRDL;
        end
      end
      S_UPMAP: begin
        mreq = '{we: 1'b1, addr: pick_q.key, wdata: {MAP_IN, pslot_q}};
        state_d = S_UPRD;
      end
      S_DNRDL: begin
        haddr = SlotW'(lchild);
        if (lchild >= size_q) state_d = S_PLACE;
        else state_d = S_DNRDR;
      end
      S_DNRDR: begin
        left_d = hrd;
        haddr = SlotW'(rchild);
        state_d = S_DNCMP;
      end
      S_DNCMP: begin
        // pick smaller child; left on ties
        logic take_r;
        entry_t c;
        logic [SlotW-1:0] cs;
        take_r = (rchild < size_q) && cmp_lt;
        c = take_r ? hrd : left_q;
        cs = take_r ? SlotW'(rchild) : SlotW'(lchild);
        if (c.pri < cur_q.pri) begin
          hwe = 1'b1; haddr = slot_q; hwd = c;
          pick_d = c; pslot_d = slot_q; slot_d = cs;
          state_d = S_DNMAP;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DNMAP: begin
        mreq = '{we: 1'b1, addr: pick_q.key, wdata: {MAP_IN, pslot_q}};
        state_d = S_DNRDL;
      end
      S_PLACE: begin
        hwe = 1'b1; haddr = slot_q; hwd = cur_q;
        mreq = '{we: 1'b1, addr: cur_q.key, wdata: {MAP_IN, slot_q}};
        state_d = S_OUT;
      end
      S_TOPRD: begin
        if (size_q == '0) begin
          st_d = ST_EMPTY; state_d = S_OUT;
        end else begin
          oent_d = hrd;
          state_d = S_TOPCHK;
        end
      end
      S_TOPCHK: begin
        if (oent_q.pri == stop_q) begin
          st_d = ST_SENTINEL; state_d = S_OUT;
        end else begin
          mreq = '{we: 1'b1, addr: oent_q.key, wdata: {MAP_DONE, SlotW'(0)}};
          size_d = size_q - CountW'(1);
          haddr = SlotW'(size_q - CountW'(1));
          state_d = (size_q == CountW'(1)) ? S_OUT : S_LASTRD;
        end
      end
      S_LASTRD: begin
        cur_d = hrd; slot_d = '0;
        state_d = S_DNRDL;
      end
      S_OUT: begin
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    if (ov_q && out_ready) ov_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; clr_q <= '0; stop_q <= StopReset;
      size_q <= '0; ov_q <= 1'b0; moved_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; size_q <= size_d;
      ov_q <= ov_d; moved_q <= moved_d;
      if (cfg_we) stop_q <= cfg_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; cur_q <= cur_d; slot_q <= slot_d; start_q <= start_d;
    left_q <= left_d; pick_q <= pick_d; pslot_q <= pslot_d; where_q <= where_d;
    st_q <= st_d; oent_q <= oent_d; ks_q <= ks_d;
  end

  assign out_valid      = ov_q;
  assign status_o       = st_q;
  assign out_key_o      = oent_q.key;
  assign out_seed_o     = oent_q.seed;
  assign out_priority_o = oent_q.pri;
  assign key_state_o    = ks_q;
  assign entry_count_o  = 11'(size_q);
endmodule
`default_nettype wire

[hdl/imh_checker.sv]
// ----------------------------------------------------------------------------
// imh_checker
// Port-level checks for the indexed min-heap.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module imh_checker import imh_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status_o,
  input wire logic [1:0]  key_state_o,
  input wire logic [10:0] entry_count_o
);
  `CHK_IMPL(a_no_take_while_full, clk_i, rst_ni, out_valid, !in_ready, "took item with result pending")
  `CHK_NEXT(a_one_result, clk_i, rst_ni, in_valid && in_ready, !out_valid, "result too early")
  `CHK_IMPL(a_count_range, clk_i, rst_ni, out_valid, entry_count_o <= 11'(HeapDepth), "count overflow")
  `CHK_IMPL(a_status_range, clk_i, rst_ni, out_valid, status_o <= ST_SENTINEL && key_state_o != 2'd3, "bad code")
  `CHK_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(status_o), "result dropped")
endmodule

bind indexed_min_heap imh_checker u_imh_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status_o(status_o),
  .key_state_o(key_state_o), .entry_count_o(entry_count_o)
);
`default_nettype wire

[tb/tb_indexed_min_heap.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap
// Checks the indexed min-heap against a behavioral heap model: a directed
// table of commands, then random traffic that fills and drains the heap.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap;
  import imh_pkg::*;

  localparam int unsigned NumRandom = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command_i = CMD_LOOKUP;
  logic [15:0] voxel_key_i = '0;
  logic [15:0] seed_tag_i = '0;
  logic [31:0] priority_req_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] out_key_o;
  logic [15:0] out_seed_o;
  logic [31:0] out_priority_o;
  logic [1:0]  key_state_o;
  logic [10:0] entry_count_o;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  indexed_min_heap dut (
    .clk_i, .rst_ni, .in_valid, .in_ready, .command_i, .voxel_key_i,
    .seed_tag_i, .priority_req_i, .out_valid, .out_ready, .status_o,
    .out_key_o, .out_seed_o, .out_priority_o, .key_state_o, .entry_count_o,
    .cfg_we, .cfg_wdata
  );

  always #6 clk_i = ~clk_i;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] key;
    logic [15:0] seed;
    logic [31:0] pri;
    logic [1:0]  kstate;
    logic [10:0] count;
  } heap_result_t;

  // ---- heap model ----
  logic [15:0] hk [HeapDepth];
  logic [15:0] hs [HeapDepth];
  logic [31:0] hp [HeapDepth];
  map_tag_e    mtag [KeyCount];
  int unsigned mslot [KeyCount];
  int unsigned hsize;
  logic [31:0] stop_pri;

  heap_result_t pending_results[$];
  int errors = 0;

  function automatic void place(int unsigned s, logic [15:0] k, logic [15:0] sd,
                                logic [31:0] p);
    hk[s] = k; hs[s] = sd; hp[s] = p;
    mtag[k] = MAP_IN; mslot[k] = s;
  endfunction

  // Sift up from slot; return the final slot, flag whether it moved.
  function automatic int unsigned sift_up(int unsigned s, logic [31:0] p, output bit moved);
    int unsigned par;
    moved = 0;
    while (s > 0) begin
      par = (s - 1) / 2;
      if (p < hp[par]) begin
        place(s, hk[par], hs[par], hp[par]);
        s = par;
        moved = 1;
      end else break;
    end
    return s;
  endfunction

  function automatic int unsigned sift_down(int unsigned s, logic [31:0] p, int unsigned n);
    int unsigned l, c;
    while (2 * s + 1 < n) begin
      l = 2 * s + 1;
      c = l;
      // equal children: keep the left one
      if (l + 1 < n && hp[l+1] < hp[l]) c = l + 1;
      if (hp[c] < p) begin
        place(s, hk[c], hs[c], hp[c]);
        s = c;
      end else break;
    end
    return s;
  endfunction

  function automatic void reprioritize(logic [15:0] k, logic [15:0] sd, logic [31:0] p);
    int unsigned st, s;
    bit up;
    st = mslot[k];
    s = sift_up(st, p, up);
    if (!up) s = sift_down(st, p, hsize);
    place(s, k, sd, p);
  endfunction

  function automatic heap_result_t predict_heap(cmd_e cmd, logic [15:0] k, logic [15:0] sd,
                                                logic [31:0] p);
    heap_result_t r;
    bit present, up;
    int unsigned s;
    logic [15:0] lk, ls;
    logic [31:0] lp;
    r = '{ST_OK, '0, '0, '0, MAP_ABSENT, '0};
    present = (mtag[k] == MAP_IN);
    case (cmd)
      CMD_INSERT: begin
        if (present) reprioritize(k, sd, p);
        else if (hsize >= HeapDepth) r.status = ST_FULL;
        else begin
          s = sift_up(hsize, p, up);
          hsize++;
          place(s, k, sd, p);
        end
      end
      CMD_UPDATE: begin
        if (!present) r.status = ST_NOKEY;
        else reprioritize(k, sd, p);
      end
      CMD_EXTRACT: begin
        if (hsize == 0) r.status = ST_EMPTY;
        else begin
          r.key = hk[0]; r.seed = hs[0]; r.pri = hp[0];
          if (hp[0] == stop_pri) r.status = ST_SENTINEL;
          else begin
            mtag[hk[0]] = MAP_DONE;
            hsize--;
            if (hsize > 0) begin
              lk = hk[hsize]; ls = hs[hsize]; lp = hp[hsize];
              s = sift_down(0, lp, hsize);
              place(s, lk, ls, lp);
            end
          end
        end
      end
      default: begin
        r.key = k;
        if (present) begin
          r.kstate = MAP_IN;
          r.seed = hs[mslot[k]];
          r.pri = hp[mslot[k]];
        end else if (mtag[k] == MAP_DONE) r.kstate = MAP_DONE;
      end
    endcase
    r.count = hsize[10:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // ---- result checker ----
  int stall_mode = 0;
  always @(posedge clk_i) begin
    heap_result_t w;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", status_o, 0);
      end else begin
        w = pending_results.pop_front();
        if (status_o !== w.status) report_mismatch("status", status_o, w.status);
        if (out_key_o !== w.key) report_mismatch("out_key", out_key_o, w.key);
        if (out_seed_o !== w.seed) report_mismatch("out_seed", out_seed_o, w.seed);
        if (out_priority_o !== w.pri) report_mismatch("out_priority", out_priority_o, w.pri);
        if (key_state_o !== w.kstate) report_mismatch("key_state", key_state_o, w.kstate);
        if (entry_count_o !== w.count) report_mismatch("entry_count", entry_count_o, w.count);
      end
    end
    // stall pattern: phases of always ready, random, and mostly stalled
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---- stimulus ----
  int burst_left = 0;

  // Send one item and queue its expected result; hold valid until accepted.
  // Valid stays high into the next item of a burst and drops only for a gap.
  task automatic send_item(cmd_e cmd, logic [15:0] k, logic [15:0] sd, logic [31:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 30);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command_i <= cmd;
    voxel_key_i <= k;
    seed_tag_i <= sd;
    priority_req_i <= p;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pending_results.push_back(predict_heap(cmd, k, sd, p));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_stop(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    stop_pri = v;
  endtask

  typedef struct {
    cmd_e        cmd;
    logic [15:0] key;
    logic [15:0] seed;
    logic [31:0] pri;
    bit          fixed;  // check against typed expectation as well
    logic [2:0]  want_status;
  } dir_row_t;

  dir_row_t dir_table[] = '{
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 32'h0, 1'b1, ST_EMPTY},
    '{CMD_UPDATE,  16'h0005, 16'h0001, 32'h5, 1'b1, ST_NOKEY},
    '{CMD_LOOKUP,  16'hFFFF, 16'h0000, 32'h0, 1'b1, ST_OK},
    '{CMD_INSERT,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK},
    '{CMD_INSERT,  16'h0000, 16'h0000, 32'h0, 1'b1, ST_OK},
    '{CMD_INSERT,  16'h1234, 16'hAAAA, 32'h100, 1'b0, ST_OK},
    '{CMD_INSERT,  16'h2345, 16'h5555, 32'h100, 1'b0, ST_OK},
    '{CMD_INSERT,  16'h1234, 16'h0BB0, 32'h80, 1'b0, ST_OK},
    '{CMD_UPDATE,  16'h0000, 16'h0007, 32'h7FFF_0000, 1'b0, ST_OK},
    '{CMD_UPDATE,  16'h2345, 16'h0008, 32'h1, 1'b0, ST_OK},
    '{CMD_LOOKUP,  16'h2345, 16'h0000, 32'h0, 1'b0, ST_OK},
    '{CMD_INSERT,  16'h0042, 16'h0042, StopReset, 1'b0, ST_OK},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 32'h0, 1'b0, ST_OK},
    '{CMD_LOOKUP,  16'h2345, 16'h0000, 32'h0, 1'b0, ST_OK},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 32'h0, 1'b0, ST_OK},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 32'h0, 1'b0, ST_OK},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 32'h0, 1'b0, ST_OK},
    '{CMD_INSERT,  16'h2345, 16'h0009, 32'h3, 1'b0, ST_OK},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 32'h0, 1'b0, ST_OK},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 32'h0, 1'b0, ST_OK},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 32'h0, 1'b0, ST_OK}
  };

  initial begin
    heap_result_t r;
    int n, sel;
    logic [15:0] k;
    logic [31:0] p;
    hsize = 0;
    stop_pri = StopReset;
    for (int i = 0; i < KeyCount; i++) begin
      mtag[i] = MAP_ABSENT;
      mslot[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table; fixed rows also carry a typed status
    foreach (dir_table[i]) begin
      send_item(dir_table[i].cmd, dir_table[i].key, dir_table[i].seed, dir_table[i].pri);
      r = pending_results[$];
      if (dir_table[i].fixed && r.status != dir_table[i].want_status)
        report_mismatch("table status", r.status, dir_table[i].want_status);
    end
    // pause until the heap has answered everything
    drain_results();

    // random phases under several sentinels, extremes included
    n = 0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_stop(32'h0000_0000);
        1: write_stop(32'hFFFF_FFFF);
        2: write_stop(32'h0000_0010);
        default: write_stop(StopReset);
      endcase
      for (int i = 0; i < NumRandom / 4; i++) begin
        sel = $urandom_range(0, 99);
        // small key space so that updates and lookups hit live entries
        k = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63));
        p = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 31));
        if (sel < 40) send_item(CMD_INSERT, k, 16'($urandom), p);
        else if (sel < 55) send_item(CMD_UPDATE, k, 16'($urandom), p);
        else if (sel < 85) send_item(CMD_EXTRACT, 16'($urandom), 16'($urandom), $urandom);
        else send_item(CMD_LOOKUP, k, 16'($urandom), $urandom);
        n++;
      end
      drain_results();
    end

    // fill to capacity, hit full, then extract 40 entries with the default sentinel off
    write_stop(32'hFFFF_FFFF);
    for (int i = 0; i <= HeapDepth; i++)
      send_item(CMD_INSERT, 16'(16'h8000 + i), 16'($urandom), $urandom);
    for (int i = 0; i < 40; i++)
      send_item(CMD_EXTRACT, '0, '0, '0);
    drain_results();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(12ns * 3000000);
    $display("TB_ERROR");
    $finish;
  end
endmodule
